### src/bpc_pkg.sv
// Package for the two-button press classifier: event and item codes,
// register map, configuration and event bundle types, helper functions.
// No dependencies.
package bpc_pkg;

   // default values of the top-level parameters
   localparam int DEF_TIMER_BITS        = 16;
   localparam int DEF_MAX_CLICK_ACTIONS = 3;

   // click actions that have an enable bit in the mask
   localparam int ACTION_SLOTS  = 3;
   localparam int ACT_MASK_BASE = 11;
   localparam int COUNT_MASK_BIT = 15;
   localparam int EVENTS_PER_BUTTON = 6;

   // events one item can cause, and depth of the bundle queue
   localparam int NUM_SLOTS   = 6;
   localparam int SLOT_W      = $clog2(NUM_SLOTS);
   localparam int QUEUE_DEPTH = 2;

   // register port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [15:0] RST_LONG_TIME  = 16'd1000;
   localparam logic [15:0] RST_XLONG_TIME = 16'd3000;
   localparam logic [15:0] RST_GAP_TIME   = 16'd500;

   localparam logic [1:0] MODE_OFF   = 2'd0;
   localparam logic [1:0] MODE_MULTI = 2'd3;

   localparam logic [1:0] LOCK_IGNORE = 2'd0;
   localparam logic [1:0] LOCK_DIRECT = 2'd1;
   localparam logic [1:0] LOCK_INVERT = 2'd2;

   // slots of the event bundle, in output order
   localparam int SLOT_B0_LONG  = 0;
   localparam int SLOT_B0_XLONG = 1;
   localparam int SLOT_B1_LONG  = 2;
   localparam int SLOT_B1_XLONG = 3;
   localparam int SLOT_COUNT    = 4;
   localparam int SLOT_ACTION   = 5;
   localparam int SLOT_LEVEL    = 0;

   typedef enum logic [1:0] {
      KIND_TICK   = 2'd0,
      KIND_BUTTON = 2'd1,
      KIND_LOCK   = 2'd2
   } item_kind_type;

   typedef enum logic [2:0] {
      EV_SHORT_PRESS   = 3'd0,
      EV_SHORT_RELEASE = 3'd1,
      EV_LONG_PRESS    = 3'd2,
      EV_LONG_RELEASE  = 3'd3,
      EV_XLONG_PRESS   = 3'd4,
      EV_XLONG_RELEASE = 3'd5,
      EV_COUNT_REPORT  = 3'd6,
      EV_CLICK_ACTION  = 3'd7
   } evt_code_type;

   typedef enum logic [2:0] {
      REG_BUTTON_MODE  = 3'd0,
      REG_LONG_TIME    = 3'd1,
      REG_XLONG_TIME   = 3'd2,
      REG_GAP_TIME     = 3'd3,
      REG_LONG_EN      = 3'd4,
      REG_XLONG_EN     = 3'd5,
      REG_LOCK_MODE    = 3'd6,
      REG_EVENT_MASK   = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [1:0]  button_mode;
      logic [15:0] long_time;
      logic [15:0] xlong_time;
      logic [15:0] gap_time;
      logic        long_en;
      logic        xlong_en;
      logic [1:0]  lock_mode;
      logic [15:0] event_mask;
   } cfg_type;

   typedef struct packed {
      evt_code_type code;
      logic         button;
      logic [7:0]   clicks;
   } evt_type;

   typedef struct packed {
      logic [NUM_SLOTS-1:0]    mask;
      evt_type [NUM_SLOTS-1:0] slot;
   } bundle_type;

   // enable bit of a per-button event
   function automatic logic evt_enabled(logic [15:0] mask, logic btn, evt_code_type code);
      logic [3:0] idx;
      idx = (btn ? 4'(EVENTS_PER_BUTTON) : 4'd0) + {1'b0, code};
      return mask[idx];
   endfunction

   function automatic evt_type make_evt(evt_code_type code, logic btn, logic [7:0] clicks);
      evt_type e;
      e.code   = code;
      e.button = btn;
      e.clicks = clicks;
      return e;
   endfunction

endpackage

### src/bpc_front.sv
// Front end of the press classifier: accepts items, keeps the button,
// click and lock state, and pushes one bundle of events for each item that causes an enabled event.
// Depends on bpc_pkg.
module bpc_front import bpc_pkg::*; #(
   parameter int TIMER_BITS        = DEF_TIMER_BITS,
   parameter int MAX_CLICK_ACTIONS = DEF_MAX_CLICK_ACTIONS
) (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          in_valid,
   output logic          in_ready,
   input  item_kind_type in_kind,
   input  logic          in_sel,
   input  logic          in_level,
   input  logic          q_full,
   output logic          push,
   output bundle_type    push_bundle
);

   logic [1:0]            pressed_ff, pressed_in;
   logic [1:0]            long_ff, long_in;
   logic [1:0]            xlong_ff, xlong_in;
   logic [TIMER_BITS-1:0] hold_ff [2];
   logic [TIMER_BITS-1:0] hold_in [2];
   logic [7:0]            tally_ff, tally_in;
   logic                  armed_ff, armed_in;
   logic [TIMER_BITS-1:0] gap_ff, gap_in;
   logic                  locked_ff, locked_in;
   logic                  accept;

   assign in_ready = !q_full;
   assign accept   = in_valid && !q_full;
   assign push     = accept && (|push_bundle.mask);

   // next state and event bundle for the accepted item
   always_comb begin
      logic [TIMER_BITS-1:0] h;
      logic [TIMER_BITS-1:0] g;
      logic [7:0]            n;
      logic                  act_ok;
      logic                  was_long;
      pressed_in  = pressed_ff;
      long_in     = long_ff;
      xlong_in    = xlong_ff;
      hold_in     = hold_ff;
      tally_in    = tally_ff;
      armed_in    = armed_ff;
      gap_in      = gap_ff;
      locked_in   = locked_ff;
      push_bundle = '0;
      h           = '0;
      g           = '0;
      n           = tally_ff;
      act_ok      = 1'b0;
      was_long    = 1'b0;
      if (accept && cfg.button_mode != MODE_OFF) begin
         unique case (in_kind)
            KIND_TICK: begin
               // hold checks, button 0 then button 1
               for (int b = 0; b < 2; b++) begin
                  if (pressed_ff[b] && (cfg.long_en || cfg.xlong_en)) begin
                     h = (hold_ff[b] == '1) ? hold_ff[b] : hold_ff[b] + 1'b1;
                     hold_in[b] = h;
                     if (!long_ff[b] && 32'(h) >= 32'(cfg.long_time)) begin
                        long_in[b] = 1'b1;
                        push_bundle.mask[2*b] =
                           evt_enabled(cfg.event_mask, 1'(b), EV_LONG_PRESS);
                        push_bundle.slot[2*b] = make_evt(EV_LONG_PRESS, 1'(b), 8'd0);
                     end
                     if (cfg.xlong_en && !xlong_ff[b] && 32'(h) >= 32'(cfg.xlong_time)) begin
                        xlong_in[b] = 1'b1;
                        push_bundle.mask[2*b+1] =
                           evt_enabled(cfg.event_mask, 1'(b), EV_XLONG_PRESS);
                        push_bundle.slot[2*b+1] = make_evt(EV_XLONG_PRESS, 1'(b), 8'd0);
                     end
                  end
               end
               // quiet gap after the last click
               if (armed_ff) begin
                  g = (gap_ff == '1) ? gap_ff : gap_ff + 1'b1;
                  gap_in = g;
                  if (cfg.button_mode == MODE_MULTI && !pressed_ff[0] &&
                      32'(g) >= 32'(cfg.gap_time)) begin
                     act_ok = (n >= 8'd1) && (32'(n) <= 32'(MAX_CLICK_ACTIONS)) &&
                              (n <= 8'(ACTION_SLOTS)) &&
                              cfg.event_mask[4'(ACT_MASK_BASE) + n[3:0]];
                     push_bundle.mask[SLOT_COUNT]  = cfg.event_mask[COUNT_MASK_BIT];
                     push_bundle.slot[SLOT_COUNT]  = make_evt(EV_COUNT_REPORT, 1'b0, n);
                     push_bundle.mask[SLOT_ACTION] = act_ok;
                     push_bundle.slot[SLOT_ACTION] = make_evt(EV_CLICK_ACTION, 1'b0, n);
                     tally_in = '0;
                     armed_in = 1'b0;
                     gap_in   = '0;
                  end
               end
            end
            KIND_BUTTON: begin
               if (in_level && !pressed_ff[in_sel] && !locked_ff) begin
                  // press
                  if (cfg.button_mode == MODE_MULTI && !in_sel) begin
                     tally_in = (tally_ff == 8'hFF) ? tally_ff : tally_ff + 8'd1;
                     armed_in = 1'b1;
                     gap_in   = '0;
                  end else begin
                     push_bundle.mask[SLOT_LEVEL] =
                        evt_enabled(cfg.event_mask, in_sel, EV_SHORT_PRESS);
                     push_bundle.slot[SLOT_LEVEL] = make_evt(EV_SHORT_PRESS, in_sel, 8'd0);
                  end
                  pressed_in[in_sel] = 1'b1;
                  long_in[in_sel]    = 1'b0;
                  xlong_in[in_sel]   = 1'b0;
                  hold_in[in_sel]    = '0;
               end else if (!in_level && pressed_ff[in_sel]) begin
                  // release
                  was_long = long_ff[in_sel] || xlong_ff[in_sel];
                  if (xlong_ff[in_sel]) begin
                     push_bundle.mask[SLOT_LEVEL] =
                        evt_enabled(cfg.event_mask, in_sel, EV_XLONG_RELEASE);
                     push_bundle.slot[SLOT_LEVEL] = make_evt(EV_XLONG_RELEASE, in_sel, 8'd0);
                  end else if (long_ff[in_sel]) begin
                     push_bundle.mask[SLOT_LEVEL] =
                        evt_enabled(cfg.event_mask, in_sel, EV_LONG_RELEASE);
                     push_bundle.slot[SLOT_LEVEL] = make_evt(EV_LONG_RELEASE, in_sel, 8'd0);
                  end else if (cfg.button_mode == MODE_MULTI) begin
                     if (!in_sel) begin
                        armed_in = 1'b1;
                        gap_in   = '0;
                     end
                  end else begin
                     push_bundle.mask[SLOT_LEVEL] =
                        evt_enabled(cfg.event_mask, in_sel, EV_SHORT_RELEASE);
                     push_bundle.slot[SLOT_LEVEL] = make_evt(EV_SHORT_RELEASE, in_sel, 8'd0);
                  end
                  if (was_long && !in_sel) begin
                     tally_in = '0;
                     armed_in = 1'b0;
                     gap_in   = '0;
                  end
                  pressed_in[in_sel] = 1'b0;
                  long_in[in_sel]    = 1'b0;
                  xlong_in[in_sel]   = 1'b0;
                  hold_in[in_sel]    = '0;
               end
            end
            KIND_LOCK: begin
               if (cfg.lock_mode != LOCK_IGNORE) begin
                  if (cfg.lock_mode == LOCK_DIRECT) begin
                     locked_in = in_level;
                  end else if (cfg.lock_mode == LOCK_INVERT) begin
                     locked_in = !in_level;
                  end
                  pressed_in = '0;
                  long_in    = '0;
                  xlong_in   = '0;
                  hold_in[0] = '0;
                  hold_in[1] = '0;
                  tally_in   = '0;
                  armed_in   = 1'b0;
                  gap_in     = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ff <= '0;
         long_ff    <= '0;
         xlong_ff   <= '0;
         hold_ff[0] <= '0;
         hold_ff[1] <= '0;
         tally_ff   <= '0;
         armed_ff   <= 1'b0;
         gap_ff     <= '0;
         locked_ff  <= 1'b0;
      end else begin
         pressed_ff <= pressed_in;
         long_ff    <= long_in;
         xlong_ff   <= xlong_in;
         hold_ff    <= hold_in;
         tally_ff   <= tally_in;
         armed_ff   <= armed_in;
         gap_ff     <= gap_in;
         locked_ff  <= locked_in;
      end
   end

endmodule

### src/bpc_queue.sv
// Short bundle queue between the front and back ends of the classifier.
// Depends on bpc_pkg.
module bpc_queue import bpc_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  bundle_type push_data,
   input  logic       pop,
   output bundle_type head,
   output logic       empty,
   output logic       full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bundle_type       mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CNT_W'(DEPTH));
   assign head  = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // bundle storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### src/bpc_back.sv
// Back end of the classifier: walks the head bundle one event per cycle
// (while out_ready lets it) into the output register and marks the final
// event of each item. Depends on bpc_pkg.
module bpc_back import bpc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  bundle_type   head,
   input  logic         empty,
   output logic         pop,
   output logic         out_valid,
   input  logic         out_ready,
   output evt_code_type out_code,
   output logic         out_button,
   output logic [7:0]   out_clicks,
   output logic         out_last
);

   logic [NUM_SLOTS-1:0] done_ff, done_in;
   logic                 valid_ff, valid_in;
   evt_type              evt_ff;
   logic                 last_ff;
   logic [NUM_SLOTS-1:0] remain;
   logic [NUM_SLOTS-1:0] pick;
   logic [SLOT_W-1:0]    sel;
   logic                 load;
   logic                 emit;
   logic                 last;

   assign out_valid  = valid_ff;
   assign out_code   = evt_ff.code;
   assign out_button = evt_ff.button;
   assign out_clicks = evt_ff.clicks;
   assign out_last   = last_ff;

   // lowest pending event of the head bundle
   always_comb begin
      remain = head.mask & ~done_ff;
      sel    = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (remain[i]) begin
            sel = SLOT_W'(i);
         end
      end
      pick     = NUM_SLOTS'(1) << sel;
      last     = ((remain & ~pick) == '0);
      load     = !valid_ff || out_ready;
      emit     = load && !empty;
      pop      = emit && last;
      done_in  = pop ? '0 : (emit ? (done_ff | pick) : done_ff);
      valid_in = emit ? 1'b1 : (out_ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         done_ff  <= done_in;
         valid_ff <= valid_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (emit) begin
         evt_ff  <= head.slot[sel];
         last_ff <= last;
      end
   end

endmodule

### src/button_press_classifier.sv
// Top level of the two-button press classifier: register port, front end,
// bundle queue and back end. Depends on bpc_pkg, bpc_front, bpc_queue, bpc_back.
//
// Use: items enter on the req_ stream (tuser = item kind; tdata = button
// select, level). Tick items mark one millisecond; level items report a
// button or lock level. Events leave on the rsp_ stream (tuser = event code;
// tdata = button, clicks; tlast on the final event caused by one item).
// Registers must be written through the csr_ port only while the block is
// idle; the block itself does not enforce this. The accepting edge queues
// the item's events; from the queue the first one is loaded into the output
// register, raising rsp_tvalid. Events of one item leave the output register
// one per cycle while rsp_tready is high; a tick can cause up to 6 events.
// The front end takes one item per cycle while the two-entry bundle queue has
// room; sustained throughput is set by the output port, at one event per cycle.
// When rsp_tready is low, the output register holds, the queue fills and
// req_tready drops once both queue entries are taken.
// Reset clears all button, click and lock state, loads register defaults
// and empties the queue and output register.
module button_press_classifier import bpc_pkg::*; #(
   parameter int MAX_CLICK_ACTIONS = DEF_MAX_CLICK_ACTIONS,
   parameter int TIMER_BITS        = DEF_TIMER_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   // input stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [0] button_select, [1] level
   input  logic [1:0]            req_tuser,   // [1:0] item_kind
   // event stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,   // [0] event_button, [8:1] clicks
   output logic [2:0]            rsp_tuser,   // [2:0] event_code
   output logic                  rsp_tlast,
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type       cfg_ff;
   reg_index_type reg_idx;
   logic          csr_wr;
   logic          push;
   logic          pop;
   logic          q_empty;
   logic          q_full;
   bundle_type    push_bundle;
   bundle_type    head;
   evt_code_type  out_code;
   logic          out_button;
   logic [7:0]    out_clicks;

   assign csr_pready = 1'b1;
   assign reg_idx    = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.button_mode <= MODE_OFF;
         cfg_ff.long_time   <= RST_LONG_TIME;
         cfg_ff.xlong_time  <= RST_XLONG_TIME;
         cfg_ff.gap_time    <= RST_GAP_TIME;
         cfg_ff.long_en     <= 1'b0;
         cfg_ff.xlong_en    <= 1'b0;
         cfg_ff.lock_mode   <= LOCK_IGNORE;
         cfg_ff.event_mask  <= '0;
      end else if (csr_wr) begin
         unique case (reg_idx)
            REG_BUTTON_MODE: cfg_ff.button_mode <= csr_pwdata[1:0];
            REG_LONG_TIME:   cfg_ff.long_time   <= csr_pwdata[15:0];
            REG_XLONG_TIME:  cfg_ff.xlong_time  <= csr_pwdata[15:0];
            REG_GAP_TIME:    cfg_ff.gap_time    <= csr_pwdata[15:0];
            REG_LONG_EN:     cfg_ff.long_en     <= csr_pwdata[0];
            REG_XLONG_EN:    cfg_ff.xlong_en    <= csr_pwdata[0];
            REG_LOCK_MODE:   cfg_ff.lock_mode   <= csr_pwdata[1:0];
            REG_EVENT_MASK:  cfg_ff.event_mask  <= csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // register read back
   always_comb begin
      unique case (reg_idx)
         REG_BUTTON_MODE: csr_prdata = CSR_DATA_W'(cfg_ff.button_mode);
         REG_LONG_TIME:   csr_prdata = CSR_DATA_W'(cfg_ff.long_time);
         REG_XLONG_TIME:  csr_prdata = CSR_DATA_W'(cfg_ff.xlong_time);
         REG_GAP_TIME:    csr_prdata = CSR_DATA_W'(cfg_ff.gap_time);
         REG_LONG_EN:     csr_prdata = CSR_DATA_W'(cfg_ff.long_en);
         REG_XLONG_EN:    csr_prdata = CSR_DATA_W'(cfg_ff.xlong_en);
         REG_LOCK_MODE:   csr_prdata = CSR_DATA_W'(cfg_ff.lock_mode);
         REG_EVENT_MASK:  csr_prdata = CSR_DATA_W'(cfg_ff.event_mask);
         default:         csr_prdata = '0;
      endcase
   end

   bpc_front #(
      .TIMER_BITS        (TIMER_BITS),
      .MAX_CLICK_ACTIONS (MAX_CLICK_ACTIONS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_kind     (item_kind_type'(req_tuser)),
      .in_sel      (req_tdata[0]),
      .in_level    (req_tdata[1]),
      .q_full      (q_full),
      .push        (push),
      .push_bundle (push_bundle)
   );

   bpc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_bundle),
      .pop       (pop),
      .head      (head),
      .empty     (q_empty),
      .full      (q_full)
   );

   bpc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .empty      (q_empty),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_code   (out_code),
      .out_button (out_button),
      .out_clicks (out_clicks),
      .out_last   (rsp_tlast)
   );

   assign rsp_tuser = out_code;
   assign rsp_tdata = {7'd0, out_clicks, out_button};

endmodule

### src/bpc_checker.sv
// Port-level checks for the press classifier and the bind that attaches
// them to the top level. Depends on bpc_pkg and button_press_classifier.
module bpc_checker import bpc_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // a stalled event holds still
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled event changed");

   // nothing leaves right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("event valid after reset");

   // button events carry no click count
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != EV_COUNT_REPORT && rsp_tuser != EV_CLICK_ACTION
         |-> rsp_tdata[8:1] == 8'd0)
      else $error("click count on a button event");

   // multi-click events concern button 0 and carry a non-zero count for actions
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == EV_COUNT_REPORT || rsp_tuser == EV_CLICK_ACTION)
         |-> !rsp_tdata[0] && (rsp_tuser == EV_COUNT_REPORT || rsp_tdata[8:1] != 8'd0))
      else $error("bad multi-click event");

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
